// ===== sv/odsc_pkg.sv =====
// ----------------------------------------------------------------------------
// odsc_pkg: shared types and constants for the overdrive sample chain
// Register map, reset values and the control word of the shared multiplier.
// ----------------------------------------------------------------------------
package odsc_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int GAIN_W      = 24;   // Q8.16
	localparam int LEVEL_W     = 18;   // Q2.16
	localparam int GAIN_FRAC   = 16;
	localparam int MUL_C_W     = 32;   // multiplier coefficient operand, two chunks
	localparam int MUL_CHUNK_W = 16;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);

	localparam logic [GAIN_W-1:0]     RST_GAIN_TARGET  = GAIN_W'(65536);
	localparam logic [LEVEL_W-1:0]    RST_LEVEL_TARGET = LEVEL_W'(65536);
	localparam logic [CFG_DATA_W-1:0] RST_GLIDE        = 32'd33554;
	localparam logic [CFG_DATA_W-1:0] RST_HP_PRE       = 32'd929458;
	localparam logic [CFG_DATA_W-1:0] RST_LP_TONE      = 32'd1807000;
	localparam logic [CFG_DATA_W-1:0] RST_LP_FIXED     = 32'd12740000;
	localparam logic [CFG_DATA_W-1:0] RST_HP_POST      = 32'd119200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_TARGET  = 3'd0,
		REG_LEVEL_TARGET = 3'd1,
		REG_GLIDE_RATE   = 3'd2,
		REG_HP_PRE       = 3'd3,
		REG_LP_TONE      = 3'd4,
		REG_LP_FIXED     = 3'd5,
		REG_HP_POST      = 3'd6
	} cfg_reg_t;

	// wide: shift by the coefficient width, else by the gain fraction
	typedef struct packed {
		logic start;
		logic wide;
	} mul_ctl_t;

endpackage

// ===== sv/odsc_mul.sv =====
// ----------------------------------------------------------------------------
// odsc_mul: shared rounding multiplier
// round(a * c / 2^s), ties up, from two 16-bit partial products; s is 16 or
// COEF_WIDTH. The result is ready while done is high.
// ----------------------------------------------------------------------------
module odsc_mul import odsc_pkg::*; #(
	parameter int A_WIDTH    = 36,
	parameter int COEF_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mul_ctl_t                   ctl,
	input  logic signed [A_WIDTH-1:0]  a,
	input  logic        [MUL_C_W-1:0]  c,
	output logic                       done,
	output logic signed [A_WIDTH-1:0]  result
);

	localparam int PW = A_WIDTH + MUL_CHUNK_W + 1;
	localparam int AW = A_WIDTH + MUL_C_W + 1;
	localparam logic signed [AW-1:0] HALF_COEF = AW'(1) <<< (COEF_WIDTH - 1);
	localparam logic signed [AW-1:0] HALF_GAIN = AW'(1) <<< (GAIN_FRAC - 1);

	typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_DONE} mst_t;

	mst_t                     mst_q;
	logic signed [A_WIDTH-1:0] a_q;
	logic        [MUL_C_W-1:0] c_q;
	logic                     wide_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [AW-1:0]     acc_q;

	logic        [MUL_CHUNK_W-1:0] chunk;
	logic signed [MUL_CHUNK_W:0]   chunk_s;
	logic signed [PW-1:0]          prod_next;
	logic signed [AW-1:0]          acc_sh;

	assign chunk     = (mst_q == M_LO) ? c_q[MUL_CHUNK_W-1:0] : c_q[MUL_C_W-1:MUL_CHUNK_W];
	assign chunk_s   = {1'b0, chunk};
	assign prod_next = PW'(a_q) * PW'(chunk_s);

	assign acc_sh = wide_q ? (acc_q >>> COEF_WIDTH) : (acc_q >>> GAIN_FRAC);
	assign result = acc_sh[A_WIDTH-1:0];
	assign done   = (mst_q == M_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q  <= M_IDLE;
			a_q    <= '0;
			c_q    <= '0;
			wide_q <= 1'b0;
			prod_q <= '0;
			acc_q  <= '0;
		end else begin
			unique case (mst_q)
				M_IDLE: begin
					if (ctl.start) begin
						a_q    <= a;
						c_q    <= c;
						wide_q <= ctl.wide;
						mst_q  <= M_LO;
					end
				end
				M_LO: begin
					prod_q <= prod_next;
					mst_q  <= M_HI;
				end
				M_HI: begin
					acc_q  <= AW'(prod_q) + (wide_q ? HALF_COEF : HALF_GAIN);
					prod_q <= prod_next;
					mst_q  <= M_SUM;
				end
				M_SUM: begin
					acc_q <= acc_q + (AW'(prod_q) <<< MUL_CHUNK_W);
					mst_q <= M_DONE;
				end
				M_DONE: begin
					mst_q <= M_IDLE;
				end
				default: begin
					mst_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/overdrive_sample_chain.sv =====
// ----------------------------------------------------------------------------
// overdrive_sample_chain: hard-clip overdrive on a Q1.23 sample stream
// Input high-passes, smoothed drive gain, hard clip, tone low-passes, output
// high-pass and smoothed level, all on one shared rounding multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write the seven registers;
//    cfg_ready is always high. Write only while the block is idle.
//  - Input beat: in_valid high and in_stall low. in_stall is high from the
//    beat until the result has been moved to the output register.
//  - Output beat: out_valid high and out_stall low. The output register holds
//    while stalled; the next input beat is still taken meanwhile.
//  - Each multiply is an issue step and then a wait step while the multiplier
//    runs; a smoother at or above its target skips its multiply and takes the
//    target. With gain above unity seven to nine multiplies run; in bypass the
//    filter steps are skipped. in_stall drops as out_valid rises, so the next
//    beat can be taken from then on; the chain holds one sample at a time.
//  - Reset clears filter states and smoothers and loads the register
//    defaults. A stalled output holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module overdrive_sample_chain import odsc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic        [CFG_IDX_W-1:0]    cfg_index,
	input  logic        [CFG_DATA_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam int DW   = SAMPLE_WIDTH + 12;
	localparam int ST_W = SAMPLE_WIDTH + 3;
	localparam logic signed [DW-1:0] POS_ONE = DW'(1) <<< (SAMPLE_WIDTH - 1);
	localparam logic signed [DW-1:0] NEG_ONE = -POS_ONE;
	localparam logic signed [DW-1:0] SAT_MAX = POS_ONE - DW'(1);

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;
	typedef enum logic [3:0] {
		OP_GAIN_SM, OP_HP1, OP_HP2, OP_GAIN, OP_LP1, OP_LP2, OP_HPP,
		OP_LEVEL_SM, OP_LEVEL
	} op_t;

	function automatic op_t next_op(input op_t op);
		op_t n;
		unique case (op)
			OP_GAIN_SM:  n = OP_HP1;
			OP_HP1:      n = OP_HP2;
			OP_HP2:      n = OP_GAIN;
			OP_GAIN:     n = OP_LP1;
			OP_LP1:      n = OP_LP2;
			OP_LP2:      n = OP_HPP;
			OP_HPP:      n = OP_LEVEL_SM;
			OP_LEVEL_SM: n = OP_LEVEL;
			default:     n = OP_LEVEL;
		endcase
		return n;
	endfunction

	// configuration
	logic [GAIN_W-1:0]     gain_target_q;
	logic [LEVEL_W-1:0]    level_target_q;
	logic [COEF_WIDTH-1:0] glide_q, hp_pre_q, lp_tone_q, lp_fixed_q, hp_post_q;

	// sequencer and datapath state
	state_t                        state_q;
	op_t                           step_q;
	logic                          active_q;
	logic signed [DW-1:0]          x_q;
	logic        [GAIN_W-1:0]      sg_q;
	logic        [LEVEL_W-1:0]     sl_q;
	logic signed [ST_W-1:0]        hp1_q, hp2_q, lpt_q, lpf_q, hpp_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	mul_ctl_t             mul_ctl;
	logic signed [DW-1:0] mul_a;
	logic [MUL_C_W-1:0]   mul_c;
	logic                 mul_wide;
	logic                 mul_done;
	logic signed [DW-1:0] mul_res;
	logic                 issue_skip;

	logic signed [DW-1:0] base;
	logic signed [DW-1:0] upd;
	logic signed [DW-1:0] x_minus;
	logic signed [DW-1:0] clip_v;
	logic signed [DW-1:0] sat_v;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_target_q  <= RST_GAIN_TARGET;
			level_target_q <= RST_LEVEL_TARGET;
			glide_q        <= RST_GLIDE[COEF_WIDTH-1:0];
			hp_pre_q       <= RST_HP_PRE[COEF_WIDTH-1:0];
			lp_tone_q      <= RST_LP_TONE[COEF_WIDTH-1:0];
			lp_fixed_q     <= RST_LP_FIXED[COEF_WIDTH-1:0];
			hp_post_q      <= RST_HP_POST[COEF_WIDTH-1:0];
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_TARGET:  gain_target_q  <= cfg_data[GAIN_W-1:0];
				REG_LEVEL_TARGET: level_target_q <= cfg_data[LEVEL_W-1:0];
				REG_GLIDE_RATE:   glide_q        <= cfg_data[COEF_WIDTH-1:0];
				REG_HP_PRE:       hp_pre_q       <= cfg_data[COEF_WIDTH-1:0];
				REG_LP_TONE:      lp_tone_q      <= cfg_data[COEF_WIDTH-1:0];
				REG_LP_FIXED:     lp_fixed_q     <= cfg_data[COEF_WIDTH-1:0];
				REG_HP_POST:      hp_post_q      <= cfg_data[COEF_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// operand selection for the current step
	always_comb begin
		mul_a      = '0;
		mul_c      = '0;
		mul_wide   = 1'b1;
		issue_skip = 1'b0;
		base       = '0;
		unique case (step_q)
			OP_GAIN_SM: begin
				mul_a      = DW'(gain_target_q) - DW'(sg_q);
				mul_c      = MUL_C_W'(glide_q);
				issue_skip = !(gain_target_q > sg_q);
				base       = DW'(sg_q);
			end
			OP_HP1: begin
				mul_a      = x_q - DW'(hp1_q);
				mul_c      = MUL_C_W'(hp_pre_q);
				issue_skip = !active_q;
				base       = DW'(hp1_q);
			end
			OP_HP2: begin
				mul_a      = x_q - DW'(hp2_q);
				mul_c      = MUL_C_W'(hp_pre_q);
				issue_skip = !active_q;
				base       = DW'(hp2_q);
			end
			OP_GAIN: begin
				mul_a    = x_q;
				mul_c    = MUL_C_W'(sg_q);
				mul_wide = 1'b0;
			end
			OP_LP1: begin
				mul_a      = x_q - DW'(lpt_q);
				mul_c      = MUL_C_W'(lp_tone_q);
				issue_skip = !active_q;
				base       = DW'(lpt_q);
			end
			OP_LP2: begin
				mul_a      = x_q - DW'(lpf_q);
				mul_c      = MUL_C_W'(lp_fixed_q);
				issue_skip = !active_q;
				base       = DW'(lpf_q);
			end
			OP_HPP: begin
				mul_a      = x_q - DW'(hpp_q);
				mul_c      = MUL_C_W'(hp_post_q);
				issue_skip = !active_q;
				base       = DW'(hpp_q);
			end
			OP_LEVEL_SM: begin
				mul_a      = DW'(level_target_q) - DW'(sl_q);
				mul_c      = MUL_C_W'(glide_q);
				issue_skip = !(level_target_q > sl_q);
				base       = DW'(sl_q);
			end
			OP_LEVEL: begin
				mul_a    = x_q;
				mul_c    = MUL_C_W'(sl_q);
				mul_wide = 1'b0;
			end
			default: ;
		endcase
	end

	assign mul_ctl.start = (state_q == S_ISSUE) && !issue_skip;
	assign mul_ctl.wide  = mul_wide;

	// one-pole update and high-pass output share one adder pair
	assign upd     = base + mul_res;
	assign x_minus = x_q - upd;

	always_comb begin
		priority if (mul_res < NEG_ONE) clip_v = NEG_ONE;
		else if (mul_res > POS_ONE)      clip_v = POS_ONE;
		else                             clip_v = mul_res;
	end

	always_comb begin
		priority if (mul_res < NEG_ONE) sat_v = NEG_ONE;
		else if (mul_res > SAT_MAX)      sat_v = SAT_MAX;
		else                             sat_v = mul_res;
	end

	odsc_mul #(
		.A_WIDTH    (DW),
		.COEF_WIDTH (COEF_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.c      (mul_c),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= OP_GAIN_SM;
			active_q     <= 1'b0;
			x_q          <= '0;
			sg_q         <= '0;
			sl_q         <= '0;
			hp1_q        <= '0;
			hp2_q        <= '0;
			lpt_q        <= '0;
			lpf_q        <= '0;
			hpp_q        <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
		end else begin
			// in S_OUT the output register is reloaded instead
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q      <= DW'(sample_in);
						active_q <= (gain_target_q > UNITY_GAIN);
						step_q   <= OP_GAIN_SM;
						state_q  <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (issue_skip) begin
						// smoother falls straight to its target
						if (step_q == OP_GAIN_SM)
							sg_q <= gain_target_q;
						if (step_q == OP_LEVEL_SM)
							sl_q <= level_target_q;
						step_q <= next_op(step_q);
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (mul_done) begin
						unique case (step_q)
							OP_GAIN_SM:  sg_q <= upd[GAIN_W-1:0];
							OP_HP1: begin
								hp1_q <= upd[ST_W-1:0];
								x_q   <= x_minus;
							end
							OP_HP2: begin
								hp2_q <= upd[ST_W-1:0];
								x_q   <= x_minus;
							end
							OP_GAIN:     x_q <= active_q ? clip_v : mul_res;
							OP_LP1: begin
								lpt_q <= upd[ST_W-1:0];
								x_q   <= upd;
							end
							OP_LP2: begin
								lpf_q <= upd[ST_W-1:0];
								x_q   <= upd;
							end
							OP_HPP: begin
								hpp_q <= upd[ST_W-1:0];
								x_q   <= x_minus;
							end
							OP_LEVEL_SM: sl_q <= upd[LEVEL_W-1:0];
							OP_LEVEL:    x_q  <= sat_v;
							default: ;
						endcase
						if (step_q == OP_LEVEL) begin
							state_q <= S_OUT;
						end else begin
							step_q  <= next_op(step_q);
							state_q <= S_ISSUE;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						sample_out_q <= x_q[SAMPLE_WIDTH-1:0];
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WAIT))
		else $error("multiplier result arrived outside the wait step");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("output beat raised without a finished sample");

	a_bypass_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && !active_q) |=>
			($stable(hp1_q) && $stable(hp2_q) && $stable(lpt_q) &&
			 $stable(lpf_q) && $stable(hpp_q)))
		else $error("filter state moved in bypass");

endmodule

// ===== tb/sv/overdrive_sample_chain_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overdrive_sample_chain_test: self-checking bench for the overdrive chain
// Drives single-sample beats through the block under a sequence of register
// settings. A bit-exact software copy of the chain predicts every output
// beat, and each output beat is compared in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module overdrive_sample_chain_test;
	import odsc_pkg::*;

	localparam int     SAMPLE_W    = 24;
	localparam int     COEF_SHIFT  = 24;
	localparam longint FULL_SCALE  = longint'(1) << (SAMPLE_W - 1);
	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     BLOCKS      = 12;
	localparam int     BLOCK_LEN   = 140;

	// index past the register map: the write must have no effect
	localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

	class overdrive_predictor;
		logic [GAIN_W-1:0]  drive_target;
		logic [LEVEL_W-1:0] out_level_target;
		logic [23:0]        rise_k, pre_hp_k, tone_k, smooth_k, dc_k;
		longint             pre_hp_a, pre_hp_b, tone_lp, smooth_lp, dc_lp;
		longint             drive_gain, out_level;
		logic signed [SAMPLE_W-1:0] expected_samples[$];
		int                 errors;

		function new();
			drive_target     = RST_GAIN_TARGET;
			out_level_target = RST_LEVEL_TARGET;
			rise_k           = 24'(RST_GLIDE);
			pre_hp_k         = 24'(RST_HP_PRE);
			tone_k           = 24'(RST_LP_TONE);
			smooth_k         = 24'(RST_LP_FIXED);
			dc_k             = 24'(RST_HP_POST);
			pre_hp_a         = 0;
			pre_hp_b         = 0;
			tone_lp          = 0;
			smooth_lp        = 0;
			dc_lp            = 0;
			drive_gain       = 0;
			out_level        = 0;
			errors           = 0;
		endfunction

		// exact product, rounded to nearest with ties upward
		function longint scale(longint a, longint k, int shift);
			return (a * k + (longint'(1) << (shift - 1))) >>> shift;
		endfunction

		function longint glide(longint now, longint target);
			if (target > now)
				return now + scale(target - now, longint'(rise_k), COEF_SHIFT);
			return target;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_GAIN_TARGET:  drive_target     = value[GAIN_W-1:0];
				REG_LEVEL_TARGET: out_level_target = value[LEVEL_W-1:0];
				REG_GLIDE_RATE:   rise_k           = value[23:0];
				REG_HP_PRE:       pre_hp_k         = value[23:0];
				REG_LP_TONE:      tone_k           = value[23:0];
				REG_LP_FIXED:     smooth_k         = value[23:0];
				REG_HP_POST:      dc_k             = value[23:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] sample);
			longint x;
			bit     active;
			x = sample;
			active = (drive_target > UNITY_GAIN);
			if (active) begin
				pre_hp_a += scale(x - pre_hp_a, longint'(pre_hp_k), COEF_SHIFT);
				x -= pre_hp_a;
				pre_hp_b += scale(x - pre_hp_b, longint'(pre_hp_k), COEF_SHIFT);
				x -= pre_hp_b;
			end
			drive_gain = glide(drive_gain, longint'(drive_target));
			x = scale(x, drive_gain, GAIN_FRAC);
			if (active) begin
				if (x < -FULL_SCALE) x = -FULL_SCALE;
				if (x > FULL_SCALE)  x = FULL_SCALE;
				tone_lp += scale(x - tone_lp, longint'(tone_k), COEF_SHIFT);
				smooth_lp += scale(tone_lp - smooth_lp, longint'(smooth_k), COEF_SHIFT);
				x = smooth_lp;
				dc_lp += scale(x - dc_lp, longint'(dc_k), COEF_SHIFT);
				x -= dc_lp;
			end
			out_level = glide(out_level, longint'(out_level_target));
			x = scale(x, out_level, GAIN_FRAC);
			if (x < -FULL_SCALE)    x = -FULL_SCALE;
			if (x > FULL_SCALE - 1) x = FULL_SCALE - 1;
			expected_samples.push_back(x[SAMPLE_W-1:0]);
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				errors++;
				$display("%0t sample_out: expected none, got %0d", $time, got);
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t sample_out: expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_valid  = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index  = '0;
	logic [CFG_DATA_W-1:0]        cfg_data   = '0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic signed [SAMPLE_W-1:0]   sample_in  = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample_out;

	overdrive_predictor chain;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count;

	overdrive_sample_chain dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			chain.check_sample(sample_out);
	end

	// random bits above the register width must be ignored
	function automatic logic [CFG_DATA_W-1:0] pad(logic [CFG_DATA_W-1:0] v, int width);
		logic [CFG_DATA_W-1:0] keep;
		keep = (CFG_DATA_W'(1) << width) - 1;
		return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_coef(int width);
		case ($urandom_range(9))
			0:       return '0;
			1:       return (CFG_DATA_W'(1) << width) - 1;
			default: return CFG_DATA_W'($urandom) & ((CFG_DATA_W'(1) << width) - 1);
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0:       return 24'h7FFFFF;
					1:       return 24'h800000;
					2:       return 24'h000000;
					default: return 24'hFFFFFF;
				endcase
			end
			1:       return SAMPLE_W'(int'($urandom_range(511)) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		chain.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [CFG_DATA_W-1:0] gain, level, rise,
	                           pre_hp, tone, smooth, dc);
		write_reg(REG_GAIN_TARGET,  pad(gain,   GAIN_W));
		write_reg(REG_LEVEL_TARGET, pad(level,  LEVEL_W));
		write_reg(REG_GLIDE_RATE,   pad(rise,   24));
		write_reg(REG_HP_PRE,       pad(pre_hp, 24));
		write_reg(REG_LP_TONE,      pad(tone,   24));
		write_reg(REG_LP_FIXED,     pad(smooth, 24));
		write_reg(REG_HP_POST,      pad(dc,     24));
		write_reg(REG_NONE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_config();
		logic [CFG_DATA_W-1:0] gain, rise;
		case ($urandom_range(9))
			0, 1, 2: gain = $urandom_range(65536);
			3:       gain = 32'hFFFFFF;
			default: gain = $urandom_range(65536 * 40, 65537);
		endcase
		case ($urandom_range(9))
			0:       rise = '0;
			1:       rise = $urandom_range(16, 1);
			2, 3:    rise = 32'hFFFFFF;
			default: rise = CFG_DATA_W'($urandom) & 32'hFFFFFF;
		endcase
		load_config(gain, pick_coef(LEVEL_W), rise, pick_coef(24), pick_coef(24),
		            pick_coef(24), pick_coef(24));
	endtask

	// entered and left just after a falling edge
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (in_stall);
		chain.take_sample(sample_in);
		@(negedge clk);
	endtask

	// hold off input until every outstanding beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (chain.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("overdrive_sample_chain: mismatch");
		$finish;
	end

	initial begin
		chain = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct  = 32;
		recv_stall_pct = 84;

		// reset defaults: unity target so bypass, slow glide from zero
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);

		// bypass right at unity, level near x4 so both saturation bounds hit
		drain();
		load_config(65536, 262143, 32'hFFFFFF, 929458, 1807000, 12740000, 119200);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);

		// full drive with transparent filters: clip lands on exactly +-1.0
		drive_full:
		begin
			drain();
			load_config(32'hFFFFFF, 65536, 32'hFFFFFF, 0, 32'hFFFFFF, 32'hFFFFFF, 0);
			send_sample(24'h7FFFFF);
			send_sample(24'h800000);
			send_sample(24'h000000);
			send_sample(24'h000001);
			send_sample(24'hFFFFFF);
			send_sample(24'h7FFFFF);
		end

		// just above unity with a tiny glide: both targets lie below the smoothers, which fall straight to them
		drain();
		load_config(65537, 1, 1, 0, 0, 0, 0);
		repeat (4) send_sample(pick_sample());

		// everything zero
		drain();
		load_config(0, 0, 0, 0, 0, 0, 0);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);

		for (int blk = 0; blk < BLOCKS; blk++) begin
			if (blk == BLOCKS / 3) begin
				send_idle_pct  = 84;
				recv_stall_pct = 32;
			end
			if (blk == 2 * BLOCKS / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			drain();
			load_random_config();
			repeat (BLOCK_LEN) send_sample(pick_sample());
		end

		drain();
		repeat (60) @(posedge clk);
		if (chain.errors == 0 && chain.pending() == 0)
			$display("overdrive_sample_chain: match");
		else
			$display("overdrive_sample_chain: mismatch");
		$finish;
	end

endmodule
